/* hw/rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, off while rst_n is low.
`define RK4_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rk4 check failed");

// Concurrent check on clk, also active during reset.
`define RK4_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rk4 check failed");

`endif

/* hw/rtl/rk4_pkg.sv */
package rk4_pkg;

  localparam int ANG_W = 44;
  localparam int CS_W = 34;
  localparam int RED_W = 43;
  localparam int RED_STEPS = 16;

  localparam logic [26:0] TWO_PI_Q24 = 27'd105414357;
  localparam logic [26:0] PI_Q24_CUT = 27'd52707179;
  localparam logic signed [CS_W-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [CS_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CS_W-1:0] QUARTER_PI_Q30 = 34'sd843314857;
  localparam logic signed [CS_W-1:0] CORDIC_INV_GAIN = 34'sd652032874;
  localparam logic [RED_W-1:0] RED_OFFSET = 43'd3454217650176;

  localparam logic REG_STEP_LENGTH = 1'b0;
  localparam logic REG_SIGN_GAIN = 1'b1;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] nh;
    logic signed [31:0] nk;
  } carry_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [CS_W-1:0] atan_q30(input int i);
    longint unsigned sum;
    longint unsigned t;
    longint unsigned num;
    longint unsigned dvs;
    longint unsigned rem;
    int sh;
    sum = 64'd0;
    if (i == 0) begin
      return QUARTER_PI_Q30;
    end
    for (int n = 0; n < 64; n++) begin
      sh = 62 - i * (2 * n + 1);
      if (sh >= 0) begin
        num = 64'd1 << sh;
        dvs = longint'(2 * n + 1);
        rem = 64'd0;
        t = 64'd0;
        for (int b = 63; b >= 0; b--) begin
          rem = {rem[62:0], num[b]};
          t = t << 1;
          if (rem >= dvs) begin
            rem = rem - dvs;
            t = t | 64'd1;
          end
        end
        if ((n & 1) != 0) begin
          sum = sum - t;
        end else begin
          sum = sum + t;
        end
      end
    end
    return CS_W'((sum + (64'd1 << 31)) >> 32);
  endfunction

endpackage

/* hw/rtl/rk4_sincos.sv */
module rk4_sincos import rk4_pkg::*; #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [ANG_W-1:0] angle,
  output logic signed [CS_W-1:0]  cos_out,
  output logic signed [CS_W-1:0]  sin_out
);

  logic [RED_W-1:0] red_r [0:RED_STEPS];
  logic signed [ANG_W:0] off_sum;

  logic signed [CS_W-1:0] x_r [0:CORDIC_STAGES];
  logic signed [CS_W-1:0] y_r [0:CORDIC_STAGES];
  logic signed [CS_W-1:0] z_r [0:CORDIC_STAGES];
  logic                   neg_r [0:CORDIC_STAGES];

  logic [26:0]            rv;
  logic signed [27:0]     r_s;
  logic signed [CS_W-1:0] z_nxt;
  logic signed [CS_W-1:0] z_raw;
  logic                   neg_nxt;

  logic signed [CS_W-1:0] cos_r;
  logic signed [CS_W-1:0] sin_r;

  assign off_sum = (ANG_W+1)'(angle) + $signed({2'b00, RED_OFFSET});

  always_ff @(posedge clk) begin
    if (en) begin
      red_r[0] <= off_sum[RED_W-1:0];
    end
  end

  for (genvar j = 0; j < RED_STEPS; j++) begin : g_red
    localparam logic [RED_W-1:0] SUB = RED_W'(TWO_PI_Q24) << (RED_STEPS - 1 - j);
    always_ff @(posedge clk) begin
      if (en) begin
        red_r[j+1] <= (red_r[j] >= SUB) ? red_r[j] - SUB : red_r[j];
      end
    end
  end

  always_comb begin
    rv = red_r[RED_STEPS][26:0];
    r_s = $signed({1'b0, rv});
    if (rv >= PI_Q24_CUT) begin
      r_s = r_s - $signed({1'b0, TWO_PI_Q24});
    end
    z_raw = $signed({r_s, 6'b000000});
    z_nxt = z_raw;
    neg_nxt = 1'b0;
    if (z_raw > HALF_PI_Q30) begin
      z_nxt = z_raw - PI_Q30;
      neg_nxt = 1'b1;
    end else if (z_raw < -HALF_PI_Q30) begin
      z_nxt = z_raw + PI_Q30;
      neg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CORDIC_INV_GAIN;
      y_r[0] <= '0;
      z_r[0] <= z_nxt;
      neg_r[0] <= neg_nxt;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    localparam logic signed [CS_W-1:0] ATAN = atan_q30(i);
    always_ff @(posedge clk) begin
      if (en) begin
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATAN;
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATAN;
        end
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= neg_r[CORDIC_STAGES] ? -x_r[CORDIC_STAGES] : x_r[CORDIC_STAGES];
      sin_r <= neg_r[CORDIC_STAGES] ? -y_r[CORDIC_STAGES] : y_r[CORDIC_STAGES];
    end
  end

  assign cos_out = cos_r;
  assign sin_out = sin_r;

endmodule

/* hw/rtl/path_model_rk4_step_with_jacobian.sv */
// One arc-length step of a kinematic path model with its Jacobian. One item enters per clock
// unless the pipeline holds; each result passes through the angle reduction (16 subtract
// stages) and the CORDIC rotation stages on its way to the output.
// Four CORDIC pipelines run side by side, one per intermediate heading. When out_ready is low
// with a result waiting, the whole pipeline holds and in_ready drops. Write step_length and
// sign_gain only while no item is in flight.
`include "assert_macros.svh"

module path_model_rk4_step_with_jacobian import rk4_pkg::*; #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_heading,
  input  logic signed [31:0] in_curvature,
  input  logic signed [31:0] in_curvature_rate,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_next_x,
  output logic signed [31:0] out_next_y,
  output logic signed [31:0] out_next_heading,
  output logic signed [31:0] out_next_curvature,
  output logic signed [31:0] out_dx_dheading,
  output logic signed [31:0] out_dx_dcurvature,
  output logic signed [31:0] out_dy_dheading,
  output logic signed [31:0] out_dy_dcurvature,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [20:0]        cfg_wdata
);

  localparam int SC_LAT = CORDIC_STAGES + RED_STEPS + 3;

  logic [20:0]        step_length_r;
  logic signed [15:0] sign_gain_r;
  logic [25:0]        ds2_r;
  logic [42:0]        ds2_p;
  logic signed [21:0] ds_s;
  logic signed [26:0] ds2_s;
  logic               adv;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_length_r <= 21'd6554;
      sign_gain_r <= 16'sd4096;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP_LENGTH: step_length_r <= cfg_wdata;
        REG_SIGN_GAIN:   sign_gain_r <= $signed(cfg_wdata[15:0]);
        default: ;
      endcase
    end
  end

  assign ds2_p = 43'(step_length_r) * 43'(step_length_r) + 43'd32768;

  always_ff @(posedge clk) begin
    ds2_r <= ds2_p[41:16];
  end

  assign ds_s = $signed({1'b0, step_length_r});
  assign ds2_s = $signed({1'b0, ds2_r});
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  // stage 1
  logic               s1_vld_r;
  logic signed [31:0] s1_px_r, s1_py_r, s1_h_r, s1_k_r;
  logic signed [37:0] s1_dk_r, s1_du_r;
  logic signed [53:0] pk_rnd, pu_rnd;

  assign pk_rnd = ds_s * in_curvature + 54'sd32768;
  assign pu_rnd = ds_s * in_curvature_rate + 54'sd32768;

  // stage 2
  logic               s2_vld_r;
  logic signed [31:0] s2_px_r, s2_py_r, s2_h_r, s2_k_r;
  logic signed [37:0] s2_dk_r, s2_du_r;
  logic signed [43:0] s2_d2u_r;
  logic signed [59:0] p2u_rnd;

  assign p2u_rnd = s1_du_r * ds_s + 60'sd32768;

  // stage 3
  logic               s3_vld_r;
  carry_t             s3_car_r;
  logic signed [ANG_W-1:0] ang_r [0:3];
  logic signed [38:0] dk_p;
  logic signed [44:0] d2_q, d2_h;
  logic signed [ANG_W-1:0] h0_nxt, h1_nxt, h2_nxt;

  assign dk_p = 39'(s2_dk_r) + 39'sd1;
  assign d2_q = 45'(s2_d2u_r) + 45'sd2;
  assign d2_h = 45'(s2_d2u_r) + 45'sd1;
  assign h0_nxt = ANG_W'(s2_h_r) + ANG_W'($signed(dk_p[38:1]));
  assign h1_nxt = h0_nxt + ANG_W'($signed(d2_q[44:2]));
  assign h2_nxt = ANG_W'(s2_h_r) + ANG_W'(s2_dk_r) + ANG_W'($signed(d2_h[44:1]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_px_r <= in_pos_x;
      s1_py_r <= in_pos_y;
      s1_h_r <= in_heading;
      s1_k_r <= in_curvature;
      s1_dk_r <= $signed(pk_rnd[53:16]);
      s1_du_r <= $signed(pu_rnd[53:16]);
      s2_px_r <= s1_px_r;
      s2_py_r <= s1_py_r;
      s2_h_r <= s1_h_r;
      s2_k_r <= s1_k_r;
      s2_dk_r <= s1_dk_r;
      s2_du_r <= s1_du_r;
      s2_d2u_r <= $signed(p2u_rnd[59:16]);
      ang_r[0] <= ANG_W'(s2_h_r);
      ang_r[1] <= h0_nxt;
      ang_r[2] <= h1_nxt;
      ang_r[3] <= h2_nxt;
      s3_car_r.px <= s2_px_r;
      s3_car_r.py <= s2_py_r;
      s3_car_r.nh <= sat32(64'(h2_nxt));
      s3_car_r.nk <= sat32(64'(s2_k_r) + 64'(s2_du_r));
    end
  end

  // sin/cos
  logic signed [CS_W-1:0] cs [0:3];
  logic signed [CS_W-1:0] sn [0:3];

  for (genvar a = 0; a < 4; a++) begin : g_sc
    rk4_sincos #(
      .CORDIC_STAGES(CORDIC_STAGES)
    ) u_sc (
      .clk    (clk),
      .en     (adv),
      .angle  (ang_r[a]),
      .cos_out(cs[a]),
      .sin_out(sn[a])
    );
  end

  carry_t car_r [0:SC_LAT-1];
  logic [SC_LAT-1:0] sc_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_vld_r <= '0;
    end else if (adv) begin
      sc_vld_r <= {sc_vld_r[SC_LAT-2:0], s3_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      car_r[0] <= s3_car_r;
    end
  end

  for (genvar d = 1; d < SC_LAT; d++) begin : g_car
    always_ff @(posedge clk) begin
      if (adv) begin
        car_r[d] <= car_r[d-1];
      end
    end
  end

  // post stages
  logic [3:0]         q_vld_r;
  carry_t             q_car_r [0:3];
  logic signed [35:0] q1_tc_r, q1_ts_r;
  logic signed [39:0] q1_ms_r, q1_mc_r;
  logic signed [43:0] q1_m2s_r, q1_m2c_r;
  logic signed [41:0] q2_pc_r, q2_ps_r;
  logic signed [31:0] j_r [0:2][0:3];
  logic [31:0]        q3_vx_r, q3_vy_r;
  logic signed [31:0] q4_qx_r, q4_qy_r;

  logic signed [35:0] tc_nxt, ts_nxt;
  logic signed [55:0] ms_rnd, mc_rnd;
  logic signed [60:0] m2s_rnd, m2c_rnd;
  logic signed [57:0] pc_rnd, ps_rnd;
  logic signed [55:0] j1s_rnd, j1c_rnd;
  logic signed [59:0] j2s_rnd, j2c_rnd;
  logic signed [57:0] gx_rnd, gy_rnd;
  logic signed [32:0] vx_sum, vy_sum;
  logic [63:0]        qx_prod, qy_prod;

  assign tc_nxt = 36'(cs[0]) + (36'(cs[1]) <<< 1) + (36'(cs[2]) <<< 1) + 36'(cs[3]);
  assign ts_nxt = 36'(sn[0]) + (36'(sn[1]) <<< 1) + (36'(sn[2]) <<< 1) + 36'(sn[3]);
  assign ms_rnd = ds_s * sn[0] + 56'sd32768;
  assign mc_rnd = ds_s * cs[0] + 56'sd32768;
  assign m2s_rnd = ds2_s * sn[0] + 61'sd65536;
  assign m2c_rnd = ds2_s * cs[0] + 61'sd65536;

  assign pc_rnd = ds_s * q1_tc_r + 58'sd32768;
  assign ps_rnd = ds_s * q1_ts_r + 58'sd32768;
  assign j1s_rnd = sign_gain_r * q1_ms_r + 56'sd33554432;
  assign j1c_rnd = sign_gain_r * q1_mc_r + 56'sd33554432;
  assign j2s_rnd = sign_gain_r * q1_m2s_r + 60'sd33554432;
  assign j2c_rnd = sign_gain_r * q1_m2c_r + 60'sd33554432;

  assign gx_rnd = sign_gain_r * q2_pc_r + 58'sd201326592;
  assign gy_rnd = sign_gain_r * q2_ps_r + 58'sd201326592;
  assign vx_sum = 33'($signed(gx_rnd[57:27])) + 33'sd805306368;
  assign vy_sum = 33'($signed(gy_rnd[57:27])) + 33'sd805306368;

  assign qx_prod = 64'(q3_vx_r) * 64'h00000000AAAAAAAB;
  assign qy_prod = 64'(q3_vy_r) * 64'h00000000AAAAAAAB;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_vld_r <= '0;
    end else if (adv) begin
      q_vld_r <= {q_vld_r[2:0], sc_vld_r[SC_LAT-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_car_r[0] <= car_r[SC_LAT-1];
      q_car_r[1] <= q_car_r[0];
      q_car_r[2] <= q_car_r[1];
      q_car_r[3] <= q_car_r[2];
      q1_tc_r <= tc_nxt;
      q1_ts_r <= ts_nxt;
      q1_ms_r <= $signed(ms_rnd[55:16]);
      q1_mc_r <= $signed(mc_rnd[55:16]);
      q1_m2s_r <= $signed(m2s_rnd[60:17]);
      q1_m2c_r <= $signed(m2c_rnd[60:17]);
      q2_pc_r <= $signed(pc_rnd[57:16]);
      q2_ps_r <= $signed(ps_rnd[57:16]);
      j_r[0][0] <= sat32(-64'($signed(j1s_rnd[55:26])));
      j_r[0][1] <= sat32(-64'($signed(j2s_rnd[59:26])));
      j_r[0][2] <= sat32(64'($signed(j1c_rnd[55:26])));
      j_r[0][3] <= sat32(64'($signed(j2c_rnd[59:26])));
      j_r[1] <= j_r[0];
      j_r[2] <= j_r[1];
      q3_vx_r <= vx_sum[31:0];
      q3_vy_r <= vy_sum[31:0];
      q4_qx_r <= $signed({1'b0, qx_prod[63:33]}) - 32'sd268435456;
      q4_qy_r <= $signed({1'b0, qy_prod[63:33]}) - 32'sd268435456;
    end
  end

  // output register
  logic               out_valid_r;
  logic signed [31:0] out_x_r, out_y_r, out_h_r, out_k_r;
  logic signed [31:0] out_j_r [0:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= q_vld_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x_r <= sat32(64'(q_car_r[3].px) + 64'(q4_qx_r));
      out_y_r <= sat32(64'(q_car_r[3].py) + 64'(q4_qy_r));
      out_h_r <= q_car_r[3].nh;
      out_k_r <= q_car_r[3].nk;
      out_j_r <= j_r[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_next_x = out_x_r;
  assign out_next_y = out_y_r;
  assign out_next_heading = out_h_r;
  assign out_next_curvature = out_k_r;
  assign out_dx_dheading = out_j_r[0];
  assign out_dx_dcurvature = out_j_r[1];
  assign out_dy_dheading = out_j_r[2];
  assign out_dy_dcurvature = out_j_r[3];

  `RK4_ASSERT(a_stall_hold, !adv |=> $stable(q_vld_r) && $stable(sc_vld_r))
  `RK4_ASSERT(a_out_fill, adv && q_vld_r[3] |=> out_valid)
  `RK4_ASSERT(a_in_enter, in_valid && in_ready |=> s1_vld_r)

endmodule
